[sv/jse_pkg.sv]
// Shared types, character codes and a helper function for the JSON string escaper.
package jse_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] CtrlLimit   = 8'h20;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_SHORT,
    KIND_UNI
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } queue_ctrl_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] res;
    if (nib < 4'd10) begin
      res = ChZero + {4'd0, nib};
    end else begin
      res = ChLowerA + {4'd0, nib - 4'd10};
    end
    return res;
  endfunction

endpackage

[sv/jse_front.sv]
// Front end: classifies each raw byte into the escape form it needs.
module jse_front (
  input  logic [7:0]      byte_i,
  output jse_pkg::entry_t entry_o
);
  import jse_pkg::*;

  always_comb begin
    entry_o.kind = KIND_PLAIN;
    entry_o.data = byte_i;
    case (byte_i)
      ChQuote, ChBackslash: begin
        entry_o.kind = KIND_SHORT;
      end
      8'h08: begin
        entry_o.kind = KIND_SHORT;
        entry_o.data = 8'h62;
      end
      8'h0C: begin
        entry_o.kind = KIND_SHORT;
        entry_o.data = 8'h66;
      end
      8'h0A: begin
        entry_o.kind = KIND_SHORT;
        entry_o.data = 8'h6E;
      end
      8'h0D: begin
        entry_o.kind = KIND_SHORT;
        entry_o.data = 8'h72;
      end
      8'h09: begin
        entry_o.kind = KIND_SHORT;
        entry_o.data = 8'h74;
      end
      default: begin
        if (byte_i < CtrlLimit) begin
          entry_o.kind = KIND_UNI;
        end
      end
    endcase
  end

endmodule

[sv/jse_queue.sv]
// Small register queue between the classifier and the output sequencer.
module jse_queue #(
  parameter int unsigned Depth = jse_pkg::FifoDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  jse_pkg::entry_t      entry_i,
  output logic                 full_o,
  input  jse_pkg::queue_ctrl_t ctrl_i,
  output jse_pkg::queue_ctrl_t ctrl_o,
  output jse_pkg::entry_t      head_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign ctrl_o.empty = (count_q == '0);
  assign ctrl_o.pop   = do_pop;
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = ctrl_i.pop && !ctrl_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[sv/jse_back.sv]
// Back end: walks the head entry and emits its escaped bytes one per cycle while ready_i is high.
module jse_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jse_pkg::entry_t      head_i,
  input  jse_pkg::queue_ctrl_t ctrl_i,
  output jse_pkg::queue_ctrl_t ctrl_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [7:0]           byte_o,
  output logic                 last_o
);
  import jse_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       fire;

  assign valid_o      = !ctrl_i.empty;
  assign fire         = valid_o && ready_i;
  assign ctrl_o.pop   = fire && last_o;
  assign ctrl_o.empty = ctrl_i.empty;

  always_comb begin
    byte_o = head_i.data;
    last_o = 1'b1;
    case (head_i.kind)
      KIND_PLAIN: begin
        byte_o = head_i.data;
        last_o = 1'b1;
      end
      KIND_SHORT: begin
        byte_o = (idx_q == 3'd0) ? ChBackslash : head_i.data;
        last_o = (idx_q != 3'd0);
      end
      KIND_UNI: begin
        last_o = (idx_q == 3'd5);
        case (idx_q)
          3'd0:    byte_o = ChBackslash;
          3'd1:    byte_o = ChLowerU;
          3'd2:    byte_o = ChZero;
          3'd3:    byte_o = ChZero;
          3'd4:    byte_o = hex_digit(head_i.data[7:4]);
          default: byte_o = hex_digit(head_i.data[3:0]);
        endcase
      end
      default: begin
        byte_o = head_i.data;
        last_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

[sv/json_string_escaper.sv]
// Top level of the JSON string escaper.
// Each accepted input byte is classified at once and stored in a small queue; an output
// sequencer then emits its escaped form at one byte per cycle while m_axis_tready_i is
// high: one output for an ordinary byte, two for a quote, a backslash or a named control
// character, six for any other byte below 0x20, with tlast on the final byte of each
// group, so plain text flows at one byte per cycle when the output is not stalled.
// The output sequencer sets the sustained rate; the queue of FifoDepth entries lets the
// input keep accepting while the output is stalled, until the queue fills.
module json_string_escaper #(
  parameter int unsigned FifoDepth = jse_pkg::FifoDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o
);
  import jse_pkg::*;

  entry_t      front_entry;
  entry_t      head;
  logic        full;
  queue_ctrl_t q_status;
  queue_ctrl_t back_ctrl;

  jse_front u_front (
    .byte_i  (s_axis_tdata_i),
    .entry_o (front_entry)
  );

  jse_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i),
    .entry_i (front_entry),
    .full_o  (full),
    .ctrl_i  (back_ctrl),
    .ctrl_o  (q_status),
    .head_o  (head)
  );

  jse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .ctrl_i  (q_status),
    .ctrl_o  (back_ctrl),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .byte_o  (m_axis_tdata_o),
    .last_o  (m_axis_tlast_o)
  );

  assign s_axis_tready_o = !full;

endmodule

[sv/jse_checker.sv]
// Port-level checks for the JSON string escaper and their bind to the top level.
module jse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic in_fire, out_fire;

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output changed");

  // An escape sequence continues without a gap once started.
  a_seq_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("escape sequence interrupted");

  // A unicode escape always continues with a zero digit.
  a_uni_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !m_axis_tlast_o && (m_axis_tdata_o == 8'h75) |=>
      m_axis_tdata_o == 8'h30)
    else $error("unicode escape not followed by zero");

  // A high byte into an empty block comes straight out as a single result.
  a_high_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !m_axis_tvalid_o && s_axis_tdata_i[7] |=>
      m_axis_tvalid_o && m_axis_tlast_o && (m_axis_tdata_o == $past(s_axis_tdata_i)))
    else $error("high byte not passed through");

endmodule

bind json_string_escaper jse_checker u_jse_checker (.*);

[tb/sv/tb_top.sv]
// Testbench for json_string_escaper: directed table, random bytes and backpressure checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom  = 450;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned HoldAtOut  = 200;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 20;

  localparam logic [7:0] CharBackspace = 8'h08;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharNewline   = 8'h0A;
  localparam logic [7:0] CharFormFeed  = 8'h0C;
  localparam logic [7:0] CharReturn    = 8'h0D;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharZero      = 8'h30;
  localparam logic [7:0] CharLowerA    = 8'h61;
  localparam logic [7:0] CharLowerB    = 8'h62;
  localparam logic [7:0] CharLowerF    = 8'h66;
  localparam logic [7:0] CharLowerN    = 8'h6E;
  localparam logic [7:0] CharLowerR    = 8'h72;
  localparam logic [7:0] CharLowerT    = 8'h74;
  localparam logic [7:0] CharLowerU    = 8'h75;
  localparam logic [7:0] FirstPrintable = 8'h20;

  // One escaped sequence: seq[0] is emitted first.
  typedef struct packed {
    logic [2:0]      len;
    logic [5:0][7:0] seq;
  } escape_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       typed;
    escape_t    want;
  } dir_row_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
    logic [7:0] src;
  } esc_byte_t;

  localparam int unsigned NumDirected = 25;

  // Rows with typed set carry their escaped form; the rest go through escape_of.
  dir_row_t dir_rows [NumDirected] = '{
    {8'h00, 1'b1, 3'd6, 48'h30_30_30_30_75_5C},
    {8'h1F, 1'b1, 3'd6, 48'h66_31_30_30_75_5C},
    {8'h20, 1'b1, 3'd1, 48'h00_00_00_00_00_20},
    {8'h22, 1'b1, 3'd2, 48'h00_00_00_00_22_5C},
    {8'h5C, 1'b1, 3'd2, 48'h00_00_00_00_5C_5C},
    {8'h7F, 1'b1, 3'd1, 48'h00_00_00_00_00_7F},
    {8'h80, 1'b1, 3'd1, 48'h00_00_00_00_00_80},
    {8'hFF, 1'b1, 3'd1, 48'h00_00_00_00_00_FF},
    {8'h08, 1'b0, 51'd0},
    {8'h09, 1'b0, 51'd0},
    {8'h0A, 1'b0, 51'd0},
    {8'h0C, 1'b0, 51'd0},
    {8'h0D, 1'b0, 51'd0},
    {8'h01, 1'b0, 51'd0},
    {8'h0B, 1'b0, 51'd0},
    {8'h0E, 1'b0, 51'd0},
    {8'h10, 1'b0, 51'd0},
    {8'h1A, 1'b0, 51'd0},
    {8'h1E, 1'b0, 51'd0},
    {8'h21, 1'b0, 51'd0},
    {8'h41, 1'b0, 51'd0},
    {8'h62, 1'b0, 51'd0},
    {8'h75, 1'b0, 51'd0},
    {8'hAA, 1'b0, 51'd0},
    {8'h55, 1'b0, 51'd0}
  };

  logic       clk_i;
  logic       rst_ni   = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tready;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;

  esc_byte_t   pending_escapes [$];
  esc_byte_t   head;
  int unsigned mismatches  = 0;
  int unsigned bytes_in    = 0;
  int unsigned bytes_out   = 0;
  int unsigned n_plain     = 0;
  int unsigned n_short     = 0;
  int unsigned n_unicode   = 0;
  int unsigned cycles      = 0;

  json_string_escaper u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic escape_t escape_of(input logic [7:0] b);
    escape_t    e;
    logic [7:0] letter;
    logic [3:0] nib;
    e      = '0;
    letter = 8'h00;
    case (b)
      CharQuote:     letter = CharQuote;
      CharBackslash: letter = CharBackslash;
      CharBackspace: letter = CharLowerB;
      CharFormFeed:  letter = CharLowerF;
      CharNewline:   letter = CharLowerN;
      CharReturn:    letter = CharLowerR;
      CharTab:       letter = CharLowerT;
      default:       letter = 8'h00;
    endcase
    if (letter != 8'h00) begin
      e.len    = 3'd2;
      e.seq[0] = CharBackslash;
      e.seq[1] = letter;
    end else if (b < FirstPrintable) begin
      e.len    = 3'd6;
      e.seq[0] = CharBackslash;
      e.seq[1] = CharLowerU;
      e.seq[2] = CharZero;
      e.seq[3] = CharZero;
      for (int k = 0; k < 2; k++) begin
        nib = (k == 0) ? b[7:4] : b[3:0];
        e.seq[4 + k] = (nib < 4'd10) ? CharZero + 8'(nib) : CharLowerA + 8'(nib) - 8'd10;
      end
    end else begin
      e.len    = 3'd1;
      e.seq[0] = b;
    end
    return e;
  endfunction

  // Drives one request and queues its escaped bytes before the handshake completes.
  task automatic offer_byte(input logic [7:0] b, input escape_t e, input int unsigned gap);
    esc_byte_t eb;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    for (int k = 0; k < e.len; k++) begin
      eb.out_byte = e.seq[k];
      eb.last     = (k == e.len - 1);
      eb.src      = b;
      pending_escapes.insert(pending_escapes.size(), eb);
    end
    case (e.len)
      3'd1:    n_plain++;
      3'd2:    n_short++;
      default: n_unicode++;
    endcase
    do @(posedge clk_i); while (!s_tready);
    bytes_in++;
  endtask

  initial begin : stimulus
    logic [7:0]  b;
    int unsigned sel;
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < NumDirected; i++) begin
      gap = (i < 8) ? 0 : $urandom_range(0, 11);
      offer_byte(dir_rows[i].in_byte,
                 dir_rows[i].typed ? dir_rows[i].want : escape_of(dir_rows[i].in_byte), gap);
    end
    for (int i = 0; i < NumRandom; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        b = 8'($urandom_range(0, 31));
      end else if (sel == 3) begin
        b = $urandom_range(0, 1) ? CharQuote : CharBackslash;
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      gap = ((i / 60) % 3 == 2) ? 0 : $urandom_range(0, 11);
      offer_byte(b, escape_of(b), gap);
    end
    s_tvalid <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    $display("Sent %0d bytes: %0d plain, %0d short escapes, %0d \\u escapes.",
             bytes_in, n_plain, n_short, n_unicode);
    $display("Checked %0d output bytes, including a %0d-cycle output hold.",
             bytes_out, LongHold);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Output side: random stalls, quiet stretches and one long hold while input keeps coming.
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready) begin
        taken++;
        if (taken == HoldAtOut) begin
          stall = LongHold;
        end else if ((taken / 100) % 3 == 1) begin
          stall = 0;
        end else begin
          stall = $urandom_range(0, 11);
        end
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      bytes_out++;
      if (pending_escapes.size() == 0) begin
        $error("unexpected output byte %02h (last %0b)", m_tdata, m_tlast);
        mismatches++;
      end else begin
        head = pending_escapes.pop_front();
        if (m_tdata !== head.out_byte) begin
          $error("out_byte for input %02h: expected %02h, got %02h",
                 head.src, head.out_byte, m_tdata);
          mismatches++;
        end
        if (m_tlast !== head.last) begin
          $error("last for input %02h: expected %0b, got %0b", head.src, head.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d bytes outstanding.",
               cycles, pending_escapes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
